/* hdl/mtep_pkg.sv */
//------------------------------------------------------------------------------
// MIDI track event parser package
// Word types, parser state and the codes shared by the parser modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtep_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       track_start;
	} in_word_t;

	typedef struct packed {
		logic [27:0] delta_time;
		logic [2:0]  event_kind;
		logic [3:0]  status_nibble;
		logic [3:0]  channel;
		logic [6:0]  first_data;
		logic [6:0]  second_data;
		logic [7:0]  meta_type;
		logic [23:0] tempo_us;
		logic        target_match;
		logic        target_on;
	} out_word_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [27:0] vlq_accum;
		logic [27:0] held_delta;
		logic [7:0]  running_status;
		logic [6:0]  held_data;
		logic [7:0]  held_meta_type;
		logic [27:0] skip_left;
		logic [23:0] tempo_accum;
	} parse_state_t;

	localparam logic [3:0] PH_DELTA      = 4'd0;
	localparam logic [3:0] PH_STATUS     = 4'd1;
	localparam logic [3:0] PH_META_TYPE  = 4'd2;
	localparam logic [3:0] PH_META_LEN   = 4'd3;
	localparam logic [3:0] PH_SYSEX_LEN  = 4'd4;
	localparam logic [3:0] PH_SKIP_META  = 4'd5;
	localparam logic [3:0] PH_SKIP_SYSEX = 4'd6;
	localparam logic [3:0] PH_TEMPO      = 4'd7;
	localparam logic [3:0] PH_DATA1      = 4'd8;
	localparam logic [3:0] PH_DATA2      = 4'd9;

	localparam logic [2:0] KIND_NOTE_OFF  = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON   = 3'd1;
	localparam logic [2:0] KIND_OTHER_CH  = 3'd2;
	localparam logic [2:0] KIND_TEMPO     = 3'd3;
	localparam logic [2:0] KIND_OTHER_META = 3'd4;
	localparam logic [2:0] KIND_SYSEX     = 3'd5;

	localparam logic [7:0] STATUS_META  = 8'hFF;
	localparam logic [7:0] STATUS_SYSEX = 8'hF0;
	localparam logic [7:0] META_TEMPO   = 8'h51;

	localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
	localparam logic [3:0] NIB_PROGRAM   = 4'hC;
	localparam logic [3:0] NIB_PRESSURE  = 4'hD;
	localparam logic [3:0] NIB_SYSTEM    = 4'hF;

	localparam logic [6:0] TARGET_KEY_RST = 7'd60;

	localparam parse_state_t PARSE_CLEAR = '{
		phase:          PH_DELTA,
		vlq_accum:      28'd0,
		held_delta:     28'd0,
		running_status: 8'd0,
		held_data:      7'd0,
		held_meta_type: 8'd0,
		skip_left:      28'd0,
		tempo_accum:    24'd0
	};

endpackage

/* hdl/mtep_step.sv */
//------------------------------------------------------------------------------
// MIDI track event parser step
// Next parser state and the event word, if any, for one track byte.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_step import mtep_pkg::*; (
	input  parse_state_t state_q,
	input  in_word_t     word,
	input  logic [6:0]   target_key,
	output parse_state_t state_d,
	output logic         res_valid,
	output out_word_t    res
);

	parse_state_t cur;
	logic [7:0]   b;
	logic [27:0]  acc;
	logic [27:0]  skip_dec;
	logic [23:0]  tempo_n;
	logic [3:0]   rs_nib;

	function automatic out_word_t make_res(
		input logic [27:0] delta,
		input logic [2:0]  kind,
		input logic [3:0]  nib,
		input logic [3:0]  ch,
		input logic [6:0]  d1,
		input logic [6:0]  d2,
		input logic [7:0]  mt,
		input logic [23:0] tempo,
		input logic [6:0]  key
	);
		out_word_t r;
		r.delta_time    = delta;
		r.event_kind    = kind;
		r.status_nibble = nib;
		r.channel       = ch;
		r.first_data    = d1;
		r.second_data   = d2;
		r.meta_type     = mt;
		r.tempo_us      = tempo;
		r.target_match  = (nib == NIB_NOTE_ON) && (d1 == key);
		r.target_on     = r.target_match && (d2 != 7'd0);
		return r;
	endfunction

	function automatic logic [2:0] chan_kind(input logic [3:0] nib);
		if (nib == NIB_NOTE_OFF) begin
			return KIND_NOTE_OFF;
		end else if (nib == NIB_NOTE_ON) begin
			return KIND_NOTE_ON;
		end
		return KIND_OTHER_CH;
	endfunction

	assign cur      = word.track_start ? PARSE_CLEAR : state_q;
	assign b        = word.data_byte;
	assign acc      = {cur.vlq_accum[20:0], b[6:0]};
	assign skip_dec = cur.skip_left - 28'd1;
	assign tempo_n  = {cur.tempo_accum[15:0], b};
	assign rs_nib   = cur.running_status[7:4];

	always_comb begin
		state_d   = cur;
		res_valid = 1'b0;
		res       = '0;
		case (cur.phase)
			PH_STATUS: begin
				if (!b[7]) begin
					if (cur.running_status == 8'd0) begin
						state_d.phase     = PH_DELTA;
						state_d.vlq_accum = 28'd0;
					end else if (rs_nib == NIB_PROGRAM || rs_nib == NIB_PRESSURE) begin
						res_valid = 1'b1;
						res = make_res(cur.held_delta, chan_kind(rs_nib), rs_nib,
							cur.running_status[3:0], b[6:0], 7'd0, 8'd0, 24'd0, target_key);
						state_d.phase     = PH_DELTA;
						state_d.vlq_accum = 28'd0;
					end else begin
						state_d.held_data = b[6:0];
						state_d.phase     = PH_DATA2;
					end
				end else if (b == STATUS_META) begin
					state_d.running_status = 8'd0;
					state_d.phase          = PH_META_TYPE;
				end else if (b >= STATUS_SYSEX) begin
					state_d.running_status = 8'd0;
					state_d.vlq_accum      = 28'd0;
					state_d.phase          = PH_SYSEX_LEN;
				end else begin
					state_d.running_status = b;
					state_d.phase          = PH_DATA1;
				end
			end
			PH_META_TYPE: begin
				state_d.held_meta_type = b;
				state_d.tempo_accum    = 24'd0;
				state_d.vlq_accum      = 28'd0;
				state_d.phase          = PH_META_LEN;
			end
			PH_META_LEN, PH_SYSEX_LEN: begin
				if (b[7]) begin
					state_d.vlq_accum = acc;
				end else begin
					state_d.skip_left = acc;
					state_d.vlq_accum = 28'd0;
					if (acc == 28'd0) begin
						res_valid     = 1'b1;
						state_d.phase = PH_DELTA;
						if (cur.phase == PH_SYSEX_LEN) begin
							res = make_res(cur.held_delta, KIND_SYSEX, NIB_SYSTEM, 4'd0,
								7'd0, 7'd0, 8'd0, 24'd0, target_key);
						end else if (cur.held_meta_type == META_TEMPO) begin
							res = make_res(cur.held_delta, KIND_TEMPO, NIB_SYSTEM, 4'd0,
								7'd0, 7'd0, cur.held_meta_type, cur.tempo_accum, target_key);
						end else begin
							res = make_res(cur.held_delta, KIND_OTHER_META, NIB_SYSTEM, 4'd0,
								7'd0, 7'd0, cur.held_meta_type, 24'd0, target_key);
						end
					end else if (cur.phase == PH_SYSEX_LEN) begin
						state_d.phase = PH_SKIP_SYSEX;
					end else if (cur.held_meta_type == META_TEMPO) begin
						state_d.phase = PH_TEMPO;
					end else begin
						state_d.phase = PH_SKIP_META;
					end
				end
			end
			PH_TEMPO, PH_SKIP_META, PH_SKIP_SYSEX: begin
				state_d.skip_left = skip_dec;
				if (cur.phase == PH_TEMPO) begin
					state_d.tempo_accum = tempo_n;
				end
				if (skip_dec == 28'd0) begin
					res_valid         = 1'b1;
					state_d.phase     = PH_DELTA;
					state_d.vlq_accum = 28'd0;
					if (cur.phase == PH_SKIP_SYSEX) begin
						res = make_res(cur.held_delta, KIND_SYSEX, NIB_SYSTEM, 4'd0,
							7'd0, 7'd0, 8'd0, 24'd0, target_key);
					end else if (cur.held_meta_type == META_TEMPO) begin
						res = make_res(cur.held_delta, KIND_TEMPO, NIB_SYSTEM, 4'd0,
							7'd0, 7'd0, cur.held_meta_type,
							(cur.phase == PH_TEMPO) ? tempo_n : cur.tempo_accum, target_key);
					end else begin
						res = make_res(cur.held_delta, KIND_OTHER_META, NIB_SYSTEM, 4'd0,
							7'd0, 7'd0, cur.held_meta_type, 24'd0, target_key);
					end
				end
			end
			PH_DATA1: begin
				if (rs_nib == NIB_PROGRAM || rs_nib == NIB_PRESSURE) begin
					res_valid = 1'b1;
					res = make_res(cur.held_delta, chan_kind(rs_nib), rs_nib,
						cur.running_status[3:0], b[6:0], 7'd0, 8'd0, 24'd0, target_key);
					state_d.phase     = PH_DELTA;
					state_d.vlq_accum = 28'd0;
				end else begin
					state_d.held_data = b[6:0];
					state_d.phase     = PH_DATA2;
				end
			end
			PH_DATA2: begin
				res_valid = 1'b1;
				res = make_res(cur.held_delta, chan_kind(rs_nib), rs_nib,
					cur.running_status[3:0], cur.held_data, b[6:0], 8'd0, 24'd0, target_key);
				state_d.phase     = PH_DELTA;
				state_d.vlq_accum = 28'd0;
			end
			default: begin
				if (!b[7]) begin
					state_d.held_delta = acc;
					state_d.vlq_accum  = 28'd0;
					state_d.phase      = PH_STATUS;
				end else begin
					state_d.vlq_accum = acc;
					state_d.phase     = PH_DELTA;
				end
			end
		endcase
	end

endmodule

/* hdl/midi_track_event_parser_core.sv */
//------------------------------------------------------------------------------
// MIDI track event parser core
// Decodes a track body byte stream into delta-timed channel, meta and sysex
// events, with tempo capture and a note-on match on a programmable key.
//------------------------------------------------------------------------------
// One track byte is taken per clock while in_stall is low; its edge updates
// the parser state and writes any event it completes to the output register,
// or to the spare word when out_stall holds the output. A two-word buffer
// decouples the sides: in_stall rises only when the spare word is occupied,
// so with out_stall low the core sustains one byte per cycle. Users must write
// target_key (address 0) over APB only while the stream is idle; not enforced.
`timescale 1ns / 1ps

module midi_track_event_parser_core import mtep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	parse_state_t state_q;
	parse_state_t state_d;
	logic         res_valid;
	out_word_t    res;
	logic [6:0]   target_key_q;
	logic         out_valid_q;
	out_word_t    out_data_q;
	logic         skid_valid_q;
	out_word_t    skid_data_q;
	logic         in_acc;
	logic         out_acc;
	logic         cfg_wr;

	mtep_step u_step (
		.state_q    (state_q),
		.word       (in_data),
		.target_key (target_key_q),
		.state_d    (state_d),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !skid_valid_q;
	assign out_acc   = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {25'd0, target_key_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_key_q <= TARGET_KEY_RST;
		end else if (cfg_wr) begin
			target_key_q <= pwdata[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_CLEAR;
		end else if (in_acc) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_acc) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_acc && res_valid) begin
			if (out_valid_q && !out_acc) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_acc) begin
				out_data_q <= skid_data_q;
			end
		end else if (in_acc && res_valid) begin
			if (out_valid_q && !out_acc) begin
				skid_data_q <= res;
			end else begin
				out_data_q <= res;
			end
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("spare word held with output register empty");

	a_spill_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res_valid && out_valid_q && !out_acc) |=> skid_valid_q)
		else $error("event word lost while output stalled");

	a_event_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res_valid) |=> (state_q.phase == PH_DELTA && state_q.vlq_accum == 28'd0))
		else $error("parser not back at delta time after an event");

endmodule
